/* hdl/bole_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Shared widths, operation codes, status codes and the cell control word.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int DATA_W       = 32;
    localparam int OPCODE_W     = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REMOVE     = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_FIND       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Rule by which a cell decides that it holds the target position.
    localparam logic [2:0] SEL_NONE  = 3'd0;
    localparam logic [2:0] SEL_HEAD  = 3'd1;
    localparam logic [2:0] SEL_ORDER = 3'd2;
    localparam logic [2:0] SEL_FIRST = 3'd3;
    localparam logic [2:0] SEL_LAST  = 3'd4;
    localparam logic [2:0] SEL_EQUAL = 3'd5;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [2:0]        sel;
        logic [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

/* hdl/bole_cell.sv */
// ----------------------------------------------------------------------------
// List cell
// Holds one entry and its valid bit, finds the target position locally and
// shifts toward either neighbor on insertion or removal.
// ----------------------------------------------------------------------------
module bole_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bole_pkg::cell_ctl_t         ctl,
    input  logic [bole_pkg::DATA_W-1:0] left_entry,
    input  logic                        left_valid,
    input  logic [bole_pkg::DATA_W-1:0] right_entry,
    input  logic                        right_valid,
    input  logic                        hit_in,
    input  logic [bole_pkg::DATA_W-1:0] rem_in,
    output logic [bole_pkg::DATA_W-1:0] entry,
    output logic                        valid,
    output logic                        hit_out,
    output logic [bole_pkg::DATA_W-1:0] rem_out
);

    logic [bole_pkg::DATA_W-1:0] entry_reg;
    logic [bole_pkg::DATA_W-1:0] entry_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        cond;
    logic                        take;
    logic                        greater;
    logic                        less;

    assign greater = $signed(entry_reg) > $signed(ctl.value);
    assign less    = $signed(entry_reg) < $signed(ctl.value);

    always_comb begin
        case (ctl.sel)
            bole_pkg::SEL_HEAD:  cond = 1'b1;
            bole_pkg::SEL_ORDER: cond = !valid_reg || (IS_HEAD ? greater : !less);
            bole_pkg::SEL_FIRST: cond = valid_reg;
            bole_pkg::SEL_LAST:  cond = valid_reg && !right_valid;
            bole_pkg::SEL_EQUAL: cond = valid_reg && (entry_reg == ctl.value);
            default:             cond = 1'b0;
        endcase
    end

    assign take    = cond && !hit_in;
    assign hit_out = hit_in || cond;
    assign rem_out = take ? entry_reg : rem_in;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.ins) begin
            if (take) begin
                entry_next = ctl.value;
            end else if (hit_in) begin
                entry_next = left_entry;
            end
            valid_next = valid_reg || left_valid;
        end else if (ctl.rem && (take || hit_in)) begin
            entry_next = right_entry;
            valid_next = valid_reg && right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

/* hdl/bounded_ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Keeps up to CAPACITY signed values in list order in a row of cells and
// runs one list operation per word, returning one result word for each.
// The result word is registered and presented in the cycle after its word is taken.
// Throughput: one word per cycle if unstalled; the cell position chain is the path.
// Reset clears the count and the valid bits of all cells; entries need no clearing.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
    parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // opcode[2:0], value[34:3], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // status[1:0], removed_value[33:2], found[34],
                                  // entry_count[39:35]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DW    = bole_pkg::DATA_W;

    logic [bole_pkg::OPCODE_W-1:0] opcode;
    logic [DW-1:0]                 value;
    logic                          accept;
    logic                          full;
    logic                          empty;
    bole_pkg::cell_ctl_t           ctl;

    logic [DW-1:0]       entry_w [CAPACITY];
    logic [CAPACITY-1:0] valid_w;
    logic [CAPACITY:0]   hit_w;
    logic [DW-1:0]       rem_w [CAPACITY+1];

    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic [CNT_W+bole_pkg::COUNT_OUT_W-1:0] count_wide;
    logic                             out_valid_reg;
    logic [bole_pkg::STATUS_W-1:0]    status_reg;
    logic [bole_pkg::STATUS_W-1:0]    status_next;
    logic [DW-1:0]                    removed_reg;
    logic [DW-1:0]                    removed_next;
    logic                             found_reg;
    logic                             found_next;
    logic [bole_pkg::COUNT_OUT_W-1:0] ecount_reg;

    assign opcode   = s_tdata[2:0];
    assign value    = s_tdata[34:3];
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb begin
        ctl.ins   = 1'b0;
        ctl.rem   = 1'b0;
        ctl.value = value;
        case (opcode)
            bole_pkg::OP_PUSH_FRONT: begin
                ctl.sel = bole_pkg::SEL_HEAD;
                ctl.ins = accept && !full;
            end
            bole_pkg::OP_INSERT: begin
                ctl.sel = bole_pkg::SEL_ORDER;
                ctl.ins = accept && !full;
            end
            bole_pkg::OP_POP_FRONT: begin
                ctl.sel = bole_pkg::SEL_FIRST;
                ctl.rem = accept;
            end
            bole_pkg::OP_POP_BACK: begin
                ctl.sel = bole_pkg::SEL_LAST;
                ctl.rem = accept;
            end
            bole_pkg::OP_REMOVE: begin
                ctl.sel = bole_pkg::SEL_EQUAL;
                ctl.rem = accept;
            end
            bole_pkg::OP_FIND: begin
                ctl.sel = bole_pkg::SEL_EQUAL;
            end
            default: begin
                ctl.sel = bole_pkg::SEL_NONE;
            end
        endcase
    end

    assign hit_w[0] = 1'b0;
    assign rem_w[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DW-1:0] left_entry;
        logic          left_valid;
        logic [DW-1:0] right_entry;
        logic          right_valid;

        if (i == 0) begin : g_head
            assign left_entry = value;
            assign left_valid = 1'b1;
        end else begin : g_body
            assign left_entry = entry_w[i-1];
            assign left_valid = valid_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_entry = entry_w[i+1];
            assign right_valid = valid_w[i+1];
        end

        bole_cell #(
            .IS_HEAD (i == 0)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .right_entry (right_entry),
            .right_valid (right_valid),
            .hit_in      (hit_w[i]),
            .rem_in      (rem_w[i]),
            .entry       (entry_w[i]),
            .valid       (valid_w[i]),
            .hit_out     (hit_w[i+1]),
            .rem_out     (rem_w[i+1])
        );
    end

    always_comb begin
        status_next  = bole_pkg::ST_OK;
        removed_next = '0;
        found_next   = 1'b0;
        count_next   = count_reg;
        case (opcode)
            bole_pkg::OP_PUSH_FRONT, bole_pkg::OP_INSERT: begin
                if (full) begin
                    status_next = bole_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            bole_pkg::OP_POP_FRONT, bole_pkg::OP_POP_BACK, bole_pkg::OP_REMOVE: begin
                if (empty) begin
                    status_next = bole_pkg::ST_EMPTY;
                end else if (hit_w[CAPACITY]) begin
                    removed_next = rem_w[CAPACITY];
                    count_next   = count_reg - 1'b1;
                end else begin
                    status_next = bole_pkg::ST_NOT_FOUND;
                end
            end
            bole_pkg::OP_FIND: begin
                found_next = hit_w[CAPACITY];
            end
            default: begin
                status_next = bole_pkg::ST_OK;
            end
        endcase
    end

    assign count_wide = {{bole_pkg::COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
            count_reg     <= count_next;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            found_reg   <= found_next;
            ecount_reg  <= count_wide[bole_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {ecount_reg, found_reg, removed_reg, status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_valid_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_w) == int'(count_reg))
        else $error("cell valid bits disagree with the entry count");

    a_find_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (opcode == bole_pkg::OP_FIND) |=> $stable(count_reg) && $stable(valid_w))
        else $error("find changed the list");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Bounded ordered list engine testbench
// Streams list operations into the engine with bursty input and a stalling
// output side. Every word taken in is run through a queue-based list
// predictor, and each result word is checked field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAPACITY   = bole_pkg::CAPACITY_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 8;
    localparam int HOLD_LEN   = 80;
    localparam int RANDOM_OPS = 1800;

    // These opcodes select no operation; the engine reports only its count.
    localparam logic [bole_pkg::OPCODE_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [bole_pkg::OPCODE_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic [bole_pkg::DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [bole_pkg::DATA_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [bole_pkg::DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

    typedef struct {
        logic [bole_pkg::OPCODE_W-1:0] opcode;
        logic [bole_pkg::DATA_W-1:0]   value;
        bit                            drain;
    } list_op_t;

    typedef struct {
        logic [bole_pkg::STATUS_W-1:0]    status;
        logic [bole_pkg::DATA_W-1:0]      removed_value;
        logic                             found;
        logic [bole_pkg::COUNT_OUT_W-1:0] entry_count;
    } list_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    list_op_t                           pending_ops[$];
    list_result_t                       list_results_due[$];
    logic signed [bole_pkg::DATA_W-1:0] list_model[$];
    logic [bole_pkg::DATA_W-1:0]        recent_vals[$];

    int total_words   = 0;
    int words_in      = 0;
    int results_owed  = 0;
    int n_checked     = 0;
    int n_errors      = 0;
    int n_found_hits  = 0;
    int op_seen[8];
    int status_seen[4];

    int burst_left = 0;
    int gap_left   = 0;

    int hold_left  = 0;
    int holds_done = 0;
    int hold_at    = 400;
    int rx_mode    = 0;
    int rx_left    = 0;

    int idle_cycles = 0;

    bounded_ordered_list_engine #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic list_result_t apply_list_op(
        logic [bole_pkg::OPCODE_W-1:0]      op,
        logic signed [bole_pkg::DATA_W-1:0] val
    );
        list_result_t r;
        int pos;
        r.status        = bole_pkg::ST_OK;
        r.removed_value = '0;
        r.found         = 1'b0;
        case (op)
            bole_pkg::OP_PUSH_FRONT: begin
                if (list_model.size() >= CAPACITY) r.status = bole_pkg::ST_FULL;
                else list_model.push_front(val);
            end
            bole_pkg::OP_INSERT: begin
                if (list_model.size() >= CAPACITY) begin
                    r.status = bole_pkg::ST_FULL;
                end else if (list_model.size() == 0 || list_model[0] > val) begin
                    list_model.push_front(val);
                end else begin
                    pos = 1;
                    while (pos < list_model.size() && list_model[pos] < val) pos++;
                    if (pos == list_model.size()) list_model.push_back(val);
                    else list_model.insert(pos, val);
                end
            end
            bole_pkg::OP_POP_FRONT: begin
                if (list_model.size() == 0) r.status = bole_pkg::ST_EMPTY;
                else r.removed_value = list_model.pop_front();
            end
            bole_pkg::OP_POP_BACK: begin
                if (list_model.size() == 0) r.status = bole_pkg::ST_EMPTY;
                else r.removed_value = list_model.pop_back();
            end
            bole_pkg::OP_REMOVE: begin
                if (list_model.size() == 0) begin
                    r.status = bole_pkg::ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < list_model.size() && list_model[pos] != val) pos++;
                    if (pos < list_model.size()) begin
                        r.removed_value = list_model[pos];
                        list_model.delete(pos);
                    end else begin
                        r.status = bole_pkg::ST_NOT_FOUND;
                    end
                end
            end
            bole_pkg::OP_FIND: begin
                foreach (list_model[i]) if (list_model[i] == val) r.found = 1'b1;
            end
            default: begin
            end
        endcase
        r.entry_count = bole_pkg::COUNT_OUT_W'(list_model.size());
        return r;
    endfunction

    function automatic void add_op(logic [bole_pkg::OPCODE_W-1:0] op,
                                   logic [bole_pkg::DATA_W-1:0] val,
                                   bit drain = 1'b0);
        list_op_t w;
        w.opcode = op;
        w.value  = val;
        w.drain  = drain;
        pending_ops.push_back(w);
        total_words++;
        if (op == bole_pkg::OP_PUSH_FRONT || op == bole_pkg::OP_INSERT) begin
            recent_vals.push_back(val);
            if (recent_vals.size() > 16) void'(recent_vals.pop_front());
        end
    endfunction

    function automatic logic [bole_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8 && recent_vals.size() != 0)
            return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        if (r < 13) return 32'($signed($urandom_range(0, 16)) - 8);
        if (r < 18) return $urandom();
        case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_NEG1;
            default: return '0;
        endcase
    endfunction

    function automatic logic [bole_pkg::OPCODE_W-1:0] pick_opcode(int phase);
        int r;
        r = $urandom_range(0, 9);
        case (phase)
            0: begin
                if (r < 3) return bole_pkg::OP_PUSH_FRONT;
                if (r < 7) return bole_pkg::OP_INSERT;
                return 3'($urandom_range(bole_pkg::OP_POP_FRONT, bole_pkg::OP_FIND));
            end
            1: begin
                if (r < 3) return bole_pkg::OP_POP_FRONT;
                if (r < 5) return bole_pkg::OP_POP_BACK;
                if (r < 8) return bole_pkg::OP_REMOVE;
                return 3'($urandom_range(bole_pkg::OP_PUSH_FRONT, OP_SPARE_B));
            end
            default: begin
                r = $urandom_range(0, 15);
                if (r < 14) return 3'(r % 6);
                return (r == 14) ? OP_SPARE_A : OP_SPARE_B;
            end
        endcase
    endfunction

    // Stimulus and end of run.
    initial begin
        int phase;
        int phase_left;
        int n;
        logic [bole_pkg::OPCODE_W-1:0] op;

        add_op(bole_pkg::OP_FIND, VAL_MAX);
        add_op(bole_pkg::OP_POP_FRONT, '0);
        add_op(bole_pkg::OP_POP_BACK, VAL_NEG1);
        add_op(bole_pkg::OP_REMOVE, VAL_MIN);
        add_op(bole_pkg::OP_INSERT, '0);
        add_op(bole_pkg::OP_INSERT, VAL_NEG1);
        add_op(bole_pkg::OP_INSERT, VAL_MAX);
        add_op(bole_pkg::OP_INSERT, '0);
        add_op(bole_pkg::OP_PUSH_FRONT, VAL_MIN);
        for (int i = 0; i < 11; i++) add_op(bole_pkg::OP_PUSH_FRONT, 32'(i * 3 + 1));
        add_op(bole_pkg::OP_PUSH_FRONT, 32'd99);
        add_op(bole_pkg::OP_INSERT, 32'd99);
        add_op(bole_pkg::OP_FIND, VAL_MAX);
        add_op(bole_pkg::OP_REMOVE, 32'd31);
        add_op(bole_pkg::OP_REMOVE, 32'd12345);
        add_op(OP_SPARE_A, VAL_NEG1);
        add_op(OP_SPARE_B, VAL_MAX);
        add_op(bole_pkg::OP_POP_FRONT, VAL_NEG1);
        add_op(bole_pkg::OP_POP_BACK, '0);

        phase      = 0;
        phase_left = 0;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (phase_left == 0) begin
                phase      = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 50);
            end
            phase_left--;
            op = pick_opcode(phase);
            add_op(op, pick_value(), n == 0 || n == RANDOM_OPS / 2);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_in != total_words || results_owed != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (list_results_due.size() != 0) begin
            $error("%0d results never arrived", list_results_due.size());
            n_errors++;
        end

        $display("tb: %0d words in, %0d results checked; push %0d, insert %0d, pop front %0d,",
                 words_in, n_checked, op_seen[bole_pkg::OP_PUSH_FRONT],
                 op_seen[bole_pkg::OP_INSERT], op_seen[bole_pkg::OP_POP_FRONT]);
        $display("tb: pop back %0d, remove %0d, find %0d (%0d hits), spare %0d; %s",
                 op_seen[bole_pkg::OP_POP_BACK], op_seen[bole_pkg::OP_REMOVE],
                 op_seen[bole_pkg::OP_FIND], n_found_hits,
                 op_seen[OP_SPARE_A] + op_seen[OP_SPARE_B],
                 $sformatf("full %0d, empty %0d, missing %0d",
                           status_seen[bole_pkg::ST_FULL], status_seen[bole_pkg::ST_EMPTY],
                           status_seen[bole_pkg::ST_NOT_FOUND]));
        if (n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // A word marked for draining is held back until every result is in.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() == 0 ||
                         (pending_ops[0].drain && (s_tvalid || results_owed != 0))) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, pending_ops[0].value, pending_ops[0].opcode};
                void'(pending_ops.pop_front());
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_done < 2 && n_checked >= hold_at) begin
            hold_left  <= HOLD_LEN;
            holds_done <= holds_done + 1;
            hold_at    <= 1300;
            m_tready   <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(10, 120);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        bit took_in;
        bit took_out;
        took_in  = aresetn && s_tvalid && s_tready;
        took_out = aresetn && m_tvalid && m_tready;
        if (took_in) begin
            list_results_due.push_back(apply_list_op(s_tdata[2:0], s_tdata[34:3]));
            op_seen[s_tdata[2:0]]++;
        end
        if (took_out) begin
            got.status        = m_tdata[1:0];
            got.removed_value = m_tdata[33:2];
            got.found         = m_tdata[34];
            got.entry_count   = m_tdata[39:35];
            if (list_results_due.size() == 0) begin
                $error("result word %h arrived with nothing pending", m_tdata);
                n_errors++;
            end else begin
                want = list_results_due.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    n_errors++;
                end
                if (got.removed_value !== want.removed_value) begin
                    $error("removed_value: expected %0d, got %0d",
                           $signed(want.removed_value), $signed(got.removed_value));
                    n_errors++;
                end
                if (got.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    n_errors++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, got.entry_count);
                    n_errors++;
                end
                status_seen[want.status]++;
                if (want.found) n_found_hits++;
            end
        end
        words_in     <= words_in + took_in;
        n_checked    <= n_checked + took_out;
        results_owed <= results_owed + took_in - took_out;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no word moved for %0d cycles", IDLE_LIMIT);
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
